>>> hw/rtl/etg_pkg.sv
// Package for the enveloped tone generator: widths, constants, command and state types,
// and the quarter-wave sine table built at elaboration.
// No dependencies; used by the top level, front, queue, back and the testbench.
package etg_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_AW = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_QUARTER = SINE_TABLE_DEPTH / 4;
  localparam int FADE_SAMPLES = 30;
  localparam int FADE_W = $clog2(FADE_SAMPLES + 1);

  localparam int LEN_W = 23;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Length is (rate_hz * dur_ms) / 1000, taken as ((x >> 3) * ceil(2^37 / 125)) >> 37.
  localparam int LEN_PROD_W = 33;
  localparam int LEN_DIV_SH = 37;
  localparam int LEN_RECIP_W = 31;
  localparam logic [LEN_RECIP_W-1:0] LEN_DIV_RECIP =
    LEN_RECIP_W'(((longint'(1) << LEN_DIV_SH) + 124) / 125);
  localparam int LEN_DIV_PROD_W = (LEN_PROD_W - 3) + LEN_RECIP_W;

  // Fade division: floor(y / FADE_SAMPLES) as (y * FDIV_RECIP) >> FDIV_SH, exact for y < 2^FDIV_N.
  localparam int MAG_W = 15;
  localparam int PROD1_W = 2 * MAG_W;
  localparam int PROD2_W = PROD1_W + FADE_W;
  localparam int FDIV_N = PROD2_W - 15;
  localparam int FDIV_L = $clog2(FADE_SAMPLES);
  localparam int FDIV_SH = FDIV_N + FDIV_L;
  localparam int FDIV_MW = FDIV_N + 1;
  localparam logic [FDIV_MW-1:0] FDIV_RECIP =
    FDIV_MW'(((longint'(1) << FDIV_SH) + FADE_SAMPLES - 1) / FADE_SAMPLES);
  localparam int SCALE_W = FDIV_N + FDIV_MW;

  localparam int CFG_AW = 4;
  localparam logic [16:0] RATE_HZ_RST = 17'd16000;
  localparam logic [23:0] PHASE_STEP_PER_HZ_RST = 24'd268435;
  localparam logic [14:0] AMPLITUDE_RST = 15'd14000;

  typedef enum logic [1:0] {
    REG_RATE_HZ = 2'd0,
    REG_PHASE_STEP_PER_HZ = 2'd1,
    REG_AMPLITUDE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic start;
    logic [LEN_W-1:0] len;
    logic [31:0] step;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    F_IDLE,
    F_LMUL,
    F_LDIV,
    F_STEP,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LOOK,
    B_MUL1,
    B_MUL2,
    B_SCALE,
    B_EMIT
  } back_state_t;

  typedef logic [MAG_W-1:0] qsine_tab_t [SINE_QUARTER+1];

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    logic [63:0] coef [7];
    logic [63:0] u;
    logic [63:0] s;
    logic [63:0] acc;
    logic [63:0] t;
    logic [63:0] v;
    coef = '{64'd1686629713, 64'd693598670, 64'd85569306, 64'd5026991,
             64'd172272, 64'd3864, 64'd66};
    for (int j = 0; j <= SINE_QUARTER; j++) begin
      u = 64'(j) << (32 - SINE_AW);
      s = (u * u) >> 30;
      acc = coef[6];
      for (int k = 5; k >= 0; k--) begin
        t = (acc * s) >> 30;
        acc = (coef[k] > t) ? (coef[k] - t) : 64'd0;
      end
      v = (((u * acc) >> 30) * 64'd32767 + 64'd536870912) >> 30;
      tab[j] = (v > 64'd32767) ? 15'd32767 : v[MAG_W-1:0];
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE_TAB = build_qsine();

endpackage

>>> hw/rtl/etg_stream_ifs.sv
// Valid/ready channel interfaces for tone requests and audio samples.
// Depends on nothing; used by the front, back and top level.
interface etg_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic [15:0] freq_hz;
  logic [15:0] dur_ms;

  modport source (output valid, start_req, freq_hz, dur_ms, input ready);
  modport sink (input valid, start_req, freq_hz, dur_ms, output ready);
endinterface

interface etg_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] sample;
  logic active;
  logic last;

  modport source (output valid, sample, active, last, input ready);
  modport sink (input valid, sample, active, last, output ready);
endinterface

>>> hw/rtl/enveloped_tone_generator.sv
// Top level of the enveloped tone generator: configuration registers and part wiring.
// Depends on etg_pkg, etg_stream_ifs, etg_front, etg_queue and etg_back.
// Each tick item gives one sample item. In the back sequencer a tick passes through queue
// pop, table read, two multiplies, fade scaling and output load, and the back pops no new
// command before its output load is done; start ticks first pass through the front, which
// computes length and phase step, overlapped with the back through a two-entry command
// queue. The front takes no new tick before it has pushed the last one's command.
// Registers sit at byte addresses 0 (output rate in hertz), 4 (phase_step_per_hz) and 8
// (amplitude) and should be written only while no tick is in flight.
module enveloped_tone_generator (
  input  logic        clk,
  input  logic        rst,
  etg_in_if.sink      tone_in,
  etg_out_if.source   tone_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [etg_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [16:0] rate_hz;
  logic [23:0] phase_step_per_hz;
  logic [14:0] amplitude;
  logic cfg_write;
  etg_pkg::cfg_reg_t cfg_sel;

  logic q_push;
  logic q_pop;
  etg_pkg::cmd_t q_data;
  etg_pkg::cmd_t q_head;
  etg_pkg::q_stat_t q_stat;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel = etg_pkg::cfg_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_hz <= etg_pkg::RATE_HZ_RST;
      phase_step_per_hz <= etg_pkg::PHASE_STEP_PER_HZ_RST;
      amplitude <= etg_pkg::AMPLITUDE_RST;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        etg_pkg::REG_RATE_HZ: rate_hz <= pwdata[16:0];
        etg_pkg::REG_PHASE_STEP_PER_HZ: phase_step_per_hz <= pwdata[23:0];
        etg_pkg::REG_AMPLITUDE: amplitude <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      etg_pkg::REG_RATE_HZ: prdata = 32'(rate_hz);
      etg_pkg::REG_PHASE_STEP_PER_HZ: prdata = 32'(phase_step_per_hz);
      etg_pkg::REG_AMPLITUDE: prdata = 32'(amplitude);
      default: prdata = '0;
    endcase
  end

  etg_front u_front (
    .clk               (clk),
    .rst               (rst),
    .tone_in           (tone_in),
    .rate_hz           (rate_hz),
    .phase_step_per_hz (phase_step_per_hz),
    .q_stat            (q_stat),
    .q_push            (q_push),
    .q_data            (q_data)
  );

  etg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  etg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .amplitude (amplitude),
    .tone_out  (tone_out)
  );

endmodule

>>> hw/rtl/etg_front.sv
// Front part: turns each tick item into a command; starts get length and step.
// Depends on etg_pkg and etg_in_if; feeds etg_queue.
module etg_front (
  input  logic                 clk,
  input  logic                 rst,
  etg_in_if.sink               tone_in,
  input  logic [16:0]          rate_hz,
  input  logic [23:0]          phase_step_per_hz,
  input  etg_pkg::q_stat_t     q_stat,
  output logic                 q_push,
  output etg_pkg::cmd_t        q_data
);

  etg_pkg::front_state_t state;
  etg_pkg::front_state_t state_next;

  logic start_r;
  logic [15:0] freq_r;
  logic [15:0] dur_r;
  logic [etg_pkg::LEN_PROD_W-1:0] len_prod;
  logic [etg_pkg::LEN_DIV_PROD_W-1:0] div_prod;
  logic [etg_pkg::LEN_W:0] len_quo;
  logic [39:0] step_prod;
  logic [etg_pkg::LEN_W-1:0] len_r;
  logic [31:0] step_r;
  logic accept;

  assign accept = tone_in.valid && tone_in.ready;
  assign len_quo = div_prod[etg_pkg::LEN_DIV_PROD_W-1:etg_pkg::LEN_DIV_SH];
  assign step_prod = 40'(freq_r) * 40'(phase_step_per_hz);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etg_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    tone_in.ready = 1'b0;
    q_push = 1'b0;
    unique case (state)
      etg_pkg::F_IDLE: begin
        tone_in.ready = 1'b1;
        if (tone_in.valid) begin
          state_next = tone_in.start_req ? etg_pkg::F_LMUL : etg_pkg::F_PUSH;
        end
      end
      etg_pkg::F_LMUL: state_next = etg_pkg::F_LDIV;
      etg_pkg::F_LDIV: state_next = etg_pkg::F_STEP;
      etg_pkg::F_STEP: state_next = etg_pkg::F_PUSH;
      etg_pkg::F_PUSH: begin
        if (!q_stat.full) begin
          q_push = 1'b1;
          state_next = etg_pkg::F_IDLE;
        end
      end
      default: state_next = etg_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      start_r <= tone_in.start_req;
      freq_r <= tone_in.freq_hz;
      dur_r <= tone_in.dur_ms;
    end
    if (state == etg_pkg::F_LMUL) begin
      len_prod <= etg_pkg::LEN_PROD_W'(rate_hz) * etg_pkg::LEN_PROD_W'(dur_r);
    end
    if (state == etg_pkg::F_LDIV) begin
      div_prod <= etg_pkg::LEN_DIV_PROD_W'(len_prod[etg_pkg::LEN_PROD_W-1:3])
                * etg_pkg::LEN_DIV_PROD_W'(etg_pkg::LEN_DIV_RECIP);
    end
    if (state == etg_pkg::F_STEP) begin
      step_r <= step_prod[31:0];
      len_r <= (len_quo > (etg_pkg::LEN_W+1)'(etg_pkg::LEN_MAX))
             ? etg_pkg::LEN_MAX : len_quo[etg_pkg::LEN_W-1:0];
    end
  end

  assign q_data.start = start_r;
  assign q_data.len = len_r;
  assign q_data.step = step_r;

endmodule

>>> hw/rtl/etg_queue.sv
// Short command queue between the front and back parts.
// Depends on etg_pkg.
module etg_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  etg_pkg::cmd_t    push_data,
  input  logic             pop,
  output etg_pkg::cmd_t    head,
  output etg_pkg::q_stat_t stat
);

  etg_pkg::cmd_t entries [etg_pkg::QUEUE_DEPTH];
  logic [etg_pkg::QUEUE_PW-1:0] wr_ptr;
  logic [etg_pkg::QUEUE_PW-1:0] rd_ptr;
  logic [etg_pkg::QUEUE_CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign stat.full = (count == etg_pkg::QUEUE_CW'(etg_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push = push && !stat.full;
  assign do_pop = pop && !stat.empty;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> hw/rtl/etg_back.sv
// Back part: runs the tone and gives one faded sine (or zero) item per command.
// Depends on etg_pkg and etg_out_if; drains etg_queue.
module etg_back (
  input  logic             clk,
  input  logic             rst,
  input  etg_pkg::cmd_t    q_head,
  input  etg_pkg::q_stat_t q_stat,
  output logic             q_pop,
  input  logic [14:0]      amplitude,
  etg_out_if.source        tone_out
);

  etg_pkg::back_state_t state;
  etg_pkg::back_state_t state_next;

  logic [31:0] phase_acc;
  logic [31:0] phase_step;
  logic [etg_pkg::LEN_W-1:0] sample_index;
  logic [etg_pkg::LEN_W-1:0] tone_length;
  logic tone_active;

  logic [etg_pkg::SINE_AW-1:0] addr;
  logic [etg_pkg::SINE_AW-2:0] qidx;
  logic [etg_pkg::FADE_W-1:0] fade_e;
  logic [etg_pkg::LEN_W:0] index_inc;

  logic [etg_pkg::MAG_W-1:0] rom_mag;
  logic neg;
  logic is_last;
  logic [etg_pkg::FADE_W-1:0] fade;
  logic [etg_pkg::PROD1_W-1:0] prod1;
  logic [etg_pkg::PROD2_W-1:0] prod2;
  logic [etg_pkg::SCALE_W-1:0] prod3;
  logic [etg_pkg::SCALE_W-1:0] quo;
  logic [14:0] mag;
  logic [15:0] signed_val;
  logic emit;

  logic out_valid;
  logic [15:0] out_sample;
  logic out_active;
  logic out_last;

  assign addr = phase_acc[31 -: etg_pkg::SINE_AW];
  assign qidx = addr[etg_pkg::SINE_AW-2]
              ? (etg_pkg::SINE_AW-1)'(etg_pkg::SINE_QUARTER) - {1'b0, addr[etg_pkg::SINE_AW-3:0]}
              : {1'b0, addr[etg_pkg::SINE_AW-3:0]};
  assign index_inc = {1'b0, sample_index} + 1'b1;

  always_comb begin
    fade_e = etg_pkg::FADE_W'(etg_pkg::FADE_SAMPLES);
    if (sample_index < etg_pkg::LEN_W'(etg_pkg::FADE_SAMPLES)) begin
      fade_e = etg_pkg::FADE_W'(sample_index);
    end
    if ({1'b0, sample_index} + (etg_pkg::LEN_W+1)'(etg_pkg::FADE_SAMPLES)
        > {1'b0, tone_length}) begin
      fade_e = etg_pkg::FADE_W'(tone_length - sample_index);
    end
  end

  assign quo = prod3 >> etg_pkg::FDIV_SH;
  assign mag = (quo > etg_pkg::SCALE_W'(32767)) ? 15'd32767 : quo[14:0];
  assign signed_val = neg ? (16'd0 - {1'b0, mag}) : {1'b0, mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etg_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    emit = 1'b0;
    unique case (state)
      etg_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          state_next = etg_pkg::B_LOOK;
        end
      end
      etg_pkg::B_LOOK: state_next = etg_pkg::B_MUL1;
      etg_pkg::B_MUL1: state_next = etg_pkg::B_MUL2;
      etg_pkg::B_MUL2: state_next = etg_pkg::B_SCALE;
      etg_pkg::B_SCALE: state_next = etg_pkg::B_EMIT;
      etg_pkg::B_EMIT: begin
        if (!out_valid || tone_out.ready) begin
          emit = 1'b1;
          state_next = etg_pkg::B_IDLE;
        end
      end
      default: state_next = etg_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      phase_step <= '0;
      sample_index <= '0;
      tone_length <= '0;
      tone_active <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop && q_head.start) begin
        phase_acc <= '0;
        phase_step <= q_head.step;
        sample_index <= '0;
        tone_length <= q_head.len;
        tone_active <= (q_head.len != '0);
      end else if (emit && tone_active) begin
        phase_acc <= phase_acc + phase_step;
        sample_index <= index_inc[etg_pkg::LEN_W-1:0];
        if (index_inc >= {1'b0, tone_length}) begin
          tone_active <= 1'b0;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (tone_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == etg_pkg::B_LOOK) begin
      rom_mag <= etg_pkg::QSINE_TAB[qidx];
      neg <= addr[etg_pkg::SINE_AW-1];
      fade <= fade_e;
      is_last <= (index_inc == {1'b0, tone_length});
    end
    if (state == etg_pkg::B_MUL1) begin
      prod1 <= etg_pkg::PROD1_W'(rom_mag) * etg_pkg::PROD1_W'(amplitude);
    end
    if (state == etg_pkg::B_MUL2) begin
      prod2 <= etg_pkg::PROD2_W'(prod1) * etg_pkg::PROD2_W'(fade);
    end
    if (state == etg_pkg::B_SCALE) begin
      prod3 <= etg_pkg::SCALE_W'(prod2[etg_pkg::PROD2_W-1:15])
             * etg_pkg::SCALE_W'(etg_pkg::FDIV_RECIP);
    end
    if (emit) begin
      out_sample <= tone_active ? signed_val : 16'd0;
      out_active <= tone_active;
      out_last <= tone_active && is_last;
    end
  end

  assign tone_out.valid = out_valid;
  assign tone_out.sample = out_sample;
  assign tone_out.active = out_active;
  assign tone_out.last = out_last;

endmodule

>>> hw/rtl/etg_checker.sv
// Port-level checks for the enveloped tone generator, bound to the top level.
// Depends only on the top level's ports.
module etg_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] sample,
  input logic        active,
  input logic        last
);

  a_reset_empties_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_idle_sample_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !active |-> sample == 16'd0 && !last)
    else $error("Idle item carries a nonzero sample or last.");

  a_last_in_tone: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> active)
    else $error("Last flag outside a tone.");

  a_stalled_item_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(active)
      && $stable(last))
    else $error("Stalled output item changed.");

endmodule

bind enveloped_tone_generator etg_checker u_etg_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (tone_out.valid),
  .out_ready (tone_out.ready),
  .sample    (tone_out.sample),
  .active    (tone_out.active),
  .last      (tone_out.last)
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the enveloped tone generator: directed and random tick items,
// paced sender, stalling receiver, APB register phases. Uses etg_pkg and etg_stream_ifs.
module tb;

  typedef struct packed {
    logic signed [15:0] sample;
    logic active;
    logic last;
  } pcm_item_t;

  typedef struct packed {
    logic start;
    logic [15:0] freq;
    logic [15:0] dur;
    logic [7:0] reps;
    logic typed;
    pcm_item_t want;
  } tick_row_t;

  typedef struct packed {
    logic [16:0] rate;
    logic [23:0] step;
    logic [14:0] amp;
  } tone_cfg_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  localparam logic [63:0] TAYLOR_Q30 [7] = '{
    64'd1686629713, 64'd693598670, 64'd85569306, 64'd5026991, 64'd172272, 64'd3864, 64'd66
  };

  localparam int PLAN_ROWS = 12;
  localparam tick_row_t PLAN [PLAN_ROWS] = '{
    '{1'b0, 16'hFFFF, 16'hFFFF, 8'd1, 1'b1, '{16'sd0, 1'b0, 1'b0}},
    '{1'b1, 16'h0000, 16'h0000, 8'd1, 1'b1, '{16'sd0, 1'b0, 1'b0}},
    '{1'b1, 16'hFFFF, 16'hFFFF, 8'd1, 1'b1, '{16'sd0, 1'b1, 1'b0}},
    '{1'b0, 16'h0000, 16'h0000, 8'd2, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{1'b1, 16'd1000, 16'd1, 8'd1, 1'b1, '{16'sd0, 1'b1, 1'b0}},
    '{1'b0, 16'h5555, 16'hAAAA, 8'd14, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{1'b0, 16'hAAAA, 16'h5555, 8'd1, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{1'b0, 16'h0000, 16'h0000, 8'd1, 1'b1, '{16'sd0, 1'b0, 1'b0}},
    '{1'b1, 16'd440, 16'd10, 8'd1, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{1'b0, 16'h1234, 16'h4321, 8'd2, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{1'b1, 16'd2000, 16'd1, 8'd1, 1'b0, '{16'sd0, 1'b0, 1'b0}},
    '{1'b0, 16'hFFFF, 16'h0000, 8'd2, 1'b0, '{16'sd0, 1'b0, 1'b0}}
  };

  localparam int FIXED_CFGS = 4;
  localparam tone_cfg_t CFG_PLAN [FIXED_CFGS] = '{
    '{17'd1000, 24'd4294967, 15'd32767},
    '{17'd96000, 24'd44739, 15'd0},
    '{17'd131071, 24'hFFFFFF, 15'd1},
    '{17'd8000, 24'd0, 15'd20000}
  };

  localparam int RANDOM_PER_PHASE = 88;
  localparam int SETTLE_CYCLES = 20;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [etg_pkg::CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  etg_in_if tone_in ();
  etg_out_if tone_out ();

  enveloped_tone_generator dut (
    .clk(clk),
    .rst(rst),
    .tone_in(tone_in),
    .tone_out(tone_out),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  int sine_lut [etg_pkg::SINE_TABLE_DEPTH];
  logic [16:0] rate_q;
  logic [23:0] step_per_hz_q;
  logic [14:0] amp_q;
  logic [31:0] phase_q;
  logic [31:0] step_q;
  logic [etg_pkg::LEN_W-1:0] idx_q;
  logic [etg_pkg::LEN_W-1:0] len_q;
  logic tone_on;

  pcm_item_t pending_pcm [$];
  int mismatches;
  int burst_left;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] q30_quarter_sine(logic [63:0] u);
    logic [63:0] s;
    logic [63:0] acc;
    logic [63:0] t;
    s = (u * u) >> 30;
    acc = TAYLOR_Q30[6];
    for (int k = 5; k >= 0; k--) begin
      t = (acc * s) >> 30;
      acc = (TAYLOR_Q30[k] > t) ? (TAYLOR_Q30[k] - t) : 64'd0;
    end
    return (u * acc) >> 30;
  endfunction

  task automatic init_tone_model();
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] u;
    logic [63:0] v;
    logic [1:0] quad;
    for (int k = 0; k < etg_pkg::SINE_TABLE_DEPTH; k++) begin
      p = 64'(k) << (32 - etg_pkg::SINE_AW);
      quad = p[31:30];
      r = p & 64'h3FFF_FFFF;
      u = quad[0] ? (64'h4000_0000 - r) : r;
      v = (q30_quarter_sine(u) * 64'd32767 + 64'h2000_0000) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      sine_lut[k] = quad[1] ? -int'(v) : int'(v);
    end
    rate_q = etg_pkg::RATE_HZ_RST;
    step_per_hz_q = etg_pkg::PHASE_STEP_PER_HZ_RST;
    amp_q = etg_pkg::AMPLITUDE_RST;
    phase_q = '0;
    step_q = '0;
    idx_q = '0;
    len_q = '0;
    tone_on = 1'b0;
  endtask

  // Advances the tone state by one tick and returns the sample item it produces.
  function automatic pcm_item_t next_pcm_sample(logic start, logic [15:0] freq,
                                                logic [15:0] dur);
    pcm_item_t res;
    logic [63:0] n64;
    logic [63:0] fade;
    logic [63:0] mag;
    logic [etg_pkg::LEN_W-1:0] i;
    int t;
    int sval;
    res = '0;
    if (start) begin
      n64 = (64'(rate_q) * 64'(dur)) / 64'd1000;
      if (n64 > 64'(etg_pkg::LEN_MAX)) begin
        n64 = 64'(etg_pkg::LEN_MAX);
      end
      len_q = n64[etg_pkg::LEN_W-1:0];
      step_q = 32'(64'(freq) * 64'(step_per_hz_q));
      phase_q = '0;
      idx_q = '0;
      tone_on = (n64 != 64'd0);
    end
    if (tone_on) begin
      i = idx_q;
      t = sine_lut[phase_q[31 -: etg_pkg::SINE_AW]];
      fade = 64'(etg_pkg::FADE_SAMPLES);
      if (64'(i) < 64'(etg_pkg::FADE_SAMPLES)) begin
        fade = 64'(i);
      end
      if (64'(i) + 64'(etg_pkg::FADE_SAMPLES) > 64'(len_q)) begin
        fade = 64'(len_q - i);
      end
      mag = 64'((t < 0) ? -t : t) * 64'(amp_q) * fade;
      mag = mag / (64'd32768 * 64'(etg_pkg::FADE_SAMPLES));
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      sval = (t < 0) ? -int'(mag) : int'(mag);
      res.sample = 16'(sval);
      res.active = 1'b1;
      res.last = ((24'(i) + 24'd1) == 24'(len_q));
      phase_q = phase_q + step_q;
      idx_q = i + 1'b1;
      if ((24'(i) + 24'd1) >= 24'(len_q)) begin
        tone_on = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic send_tick(logic start, logic [15:0] freq, logic [15:0] dur,
                           bit typed, pcm_item_t want);
    pcm_item_t got;
    tone_in.valid <= 1'b1;
    tone_in.start_req <= start;
    tone_in.freq_hz <= freq;
    tone_in.dur_ms <= dur;
    do @(posedge clk); while (!tone_in.ready);
    got = next_pcm_sample(start, freq, dur);
    pending_pcm.push_back(typed ? want : got);
  endtask

  task automatic send_paced(logic start, logic [15:0] freq, logic [15:0] dur,
                            bit typed, pcm_item_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        tone_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 16);
    end
    burst_left--;
    send_tick(start, freq, dur, typed, want);
  endtask

  task automatic drain_samples();
    tone_in.valid <= 1'b0;
    while (pending_pcm.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(etg_pkg::cfg_reg_t idx, logic [31:0] value);
    logic [31:0] want_rd;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= etg_pkg::CFG_AW'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      etg_pkg::REG_RATE_HZ: begin
        rate_q = value[16:0];
        want_rd = 32'(rate_q);
      end
      etg_pkg::REG_PHASE_STEP_PER_HZ: begin
        step_per_hz_q = value[23:0];
        want_rd = 32'(step_per_hz_q);
      end
      etg_pkg::REG_AMPLITUDE: begin
        amp_q = value[14:0];
        want_rd = 32'(amp_q);
      end
      default: begin
        want_rd = '0;
      end
    endcase
    @(posedge clk);
    if (prdata !== want_rd) begin
      $error("prdata: expected %0h, got %0h", want_rd, prdata);
      mismatches++;
    end
  endtask

  // Mostly complete tones with random content; now and then a restart mid-tone,
  // a stray tick while idle or a long tone that hits the length ceiling at the highest rates.
  task automatic run_random(int count);
    logic start;
    logic [15:0] freq;
    logic [15:0] dur;
    int lim;
    send_paced(1'b1, 16'($urandom), 16'hFFFF, 1'b0, '0);
    for (int n = 1; n < count; n++) begin
      freq = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(100, 8000)) : 16'($urandom);
      if (tone_on) begin
        start = ($urandom_range(0, 29) == 0);
      end else begin
        start = ($urandom_range(0, 3) != 0);
      end
      if (!start) begin
        dur = 16'($urandom);
      end else if ($urandom_range(0, 19) == 0) begin
        dur = 16'($urandom);
      end else begin
        lim = (rate_q >= 17'd50000) ? 1 : ((rate_q >= 17'd2000) ? 8 : 60);
        dur = 16'($urandom_range(0, lim));
      end
      send_paced(start, freq, dur, 1'b0, '0);
    end
  endtask

  initial begin
    rx_mode_t mode;
    int hold;
    int beat;
    tone_out.ready <= 1'b0;
    mode = RX_OPEN;
    hold = 0;
    beat = 0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        hold = $urandom_range(20, 120);
      end
      hold--;
      beat++;
      case (mode)
        RX_OPEN: tone_out.ready <= 1'b1;
        RX_LIGHT: tone_out.ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: tone_out.ready <= ($urandom_range(0, 3) == 0);
        default: tone_out.ready <= ((beat % 7) < 4);
      endcase
    end
  end

  always @(posedge clk) begin
    pcm_item_t want;
    if (!rst && tone_out.valid && tone_out.ready) begin
      if (pending_pcm.size() == 0) begin
        $error("sample item with nothing expected: sample %0d active %0b last %0b",
               tone_out.sample, tone_out.active, tone_out.last);
        mismatches++;
      end else begin
        want = pending_pcm.pop_front();
        if (tone_out.sample !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, tone_out.sample);
          mismatches++;
        end
        if (tone_out.active !== want.active) begin
          $error("active: expected %0b, got %0b", want.active, tone_out.active);
          mismatches++;
        end
        if (tone_out.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, tone_out.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    tone_cfg_t cfg;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tone_in.valid <= 1'b0;
    tone_in.start_req <= 1'b0;
    tone_in.freq_hz <= '0;
    tone_in.dur_ms <= '0;
    mismatches = 0;
    burst_left = 0;
    init_tone_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      for (int k = 0; k < int'(PLAN[r].reps); k++) begin
        send_paced(PLAN[r].start, PLAN[r].freq, PLAN[r].dur, PLAN[r].typed, PLAN[r].want);
      end
    end
    run_random(RANDOM_PER_PHASE);

    for (int p = 0; p <= FIXED_CFGS; p++) begin
      if (p < FIXED_CFGS) begin
        cfg = CFG_PLAN[p];
      end else begin
        cfg.rate = 17'($urandom);
        cfg.step = 24'($urandom);
        cfg.amp = 15'($urandom);
      end
      drain_samples();
      cfg_write(etg_pkg::REG_RATE_HZ, 32'(cfg.rate));
      cfg_write(etg_pkg::REG_PHASE_STEP_PER_HZ, 32'(cfg.step));
      cfg_write(etg_pkg::REG_AMPLITUDE, 32'(cfg.amp));
      run_random(RANDOM_PER_PHASE);
    end

    drain_samples();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/etg_pkg.sv
hw/rtl/etg_stream_ifs.sv
hw/rtl/etg_front.sv
hw/rtl/etg_queue.sv
hw/rtl/etg_back.sv
hw/rtl/enveloped_tone_generator.sv
hw/rtl/etg_checker.sv
tb/sv/tb.sv
